// ===== src/rcrm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rcrm_pkg;

  // Field and register widths.
  localparam int IDX_W     = 16;
  localparam int OUT_W     = 17;
  localparam int WEST_W    = 48;
  localparam int RES_W     = 47;
  localparam int COLS_W    = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 48;

  // Internal datapath widths.
  localparam int D_W    = WEST_W + 1;        // west offset, signed
  localparam int PROD_W = RES_W + IDX_W + 1; // window_res * (2i+1)
  localparam int REM_W  = 65;                // holds 2*source_res*columns
  localparam int NUM_W  = REM_W + 1;         // signed numerator

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WEST    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RES     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WEST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RES     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_COLUMNS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LATLON_MODE    = 3'd5;

  // What one divider cell hands to the next.
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] dv;
    logic [OUT_W-1:0] q;
  } cell_link_t;

  // Status of the west offset reduction unit.
  typedef struct packed {
    logic                  busy;
    logic signed [D_W-1:0] offset;
  } norm_status_t;

endpackage

`default_nettype wire

// ===== src/raster_column_resample_map_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// A result passes through five front stages, one divider cell per quotient bit and the
// output register, QB being $clog2 of the column cap (MAX_COLUMNS held to 17 bits).
// Throughput is one beat per cycle while the output does not stall and no reduction
// pass is running.
// Reset is synchronous and loads the register defaults; no reduction pass is needed then.
// Each configuration write starts a west offset reduction (load, sum, fold, divide, done),
// and the input stalls until it is done.

module raster_column_resample_map_top
  import rcrm_pkg::*;
#(
  parameter int MAX_COLUMNS   = 65536,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [IDX_W-1:0]     in_window_column,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [OUT_W-1:0]          out_source_column_plus_one,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam logic [COLS_W-1:0] COLS_CAP = (MAX_COLUMNS >= (1 << COLS_W)) ?
                                           {COLS_W{1'b1}} : COLS_W'(MAX_COLUMNS);
  localparam int QB = $clog2(COLS_CAP);
  localparam logic [NUM_W-1:0] TWO_TURN = NUM_W'(720) << FRACTION_BITS;

  // Configuration registers.
  logic signed [WEST_W-1:0] window_west_r;
  logic [RES_W-1:0]         window_res_r;
  logic signed [WEST_W-1:0] source_west_r;
  logic [RES_W-1:0]         source_res_r;
  logic [COLS_W-1:0]        source_columns_r;
  logic                     latlon_mode_r;
  logic                     cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_west_r    <= '0;
      window_res_r     <= RES_W'(65536);
      source_west_r    <= '0;
      source_res_r     <= RES_W'(65536);
      source_columns_r <= COLS_W'(1);
      latlon_mode_r    <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_WINDOW_WEST:    window_west_r    <= cfg_data;
        CFG_WINDOW_RES:     window_res_r     <= cfg_data[RES_W-1:0];
        CFG_SOURCE_WEST:    source_west_r    <= cfg_data;
        CFG_SOURCE_RES:     source_res_r     <= cfg_data[RES_W-1:0];
        CFG_SOURCE_COLUMNS: source_columns_r <= cfg_data[COLS_W-1:0];
        CFG_LATLON_MODE:    latlon_mode_r    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  norm_status_t norm_st;

  rcrm_turn_norm #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_norm (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (cfg_write),
    .window_west (window_west_r),
    .source_west (source_west_r),
    .latlon_mode (latlon_mode_r),
    .status      (norm_st)
  );

  // Limit of the numerator: twice the source cell size times the column count.
  logic [COLS_W-1:0] cols_eff;
  logic [REM_W-1:0]  lim_nxt;
  logic [REM_W-1:0]  lim_r;
  logic [REM_W-1:0]  dv_start;

  assign cols_eff = (source_columns_r > COLS_CAP) ? COLS_CAP : source_columns_r;
  assign lim_nxt  = REM_W'({source_res_r, 1'b0}) * REM_W'(cols_eff);
  assign dv_start = REM_W'({source_res_r, 1'b0}) << (QB - 1);

  always_ff @(posedge clk) begin
    lim_r <= lim_nxt;
  end

  // Front stages and the divider row, with a take signal running back from the output.
  logic                  v1_r, v2_r, v3_r, v4_r;
  logic [IDX_W:0]        a1_r;
  logic [PROD_W-1:0]     p2_r;
  logic [PROD_W-1:0]     p2_nxt;
  logic [NUM_W-1:0]      num3_r;
  logic [NUM_W-1:0]      num3_nxt;
  logic [NUM_W-1:0]      num1_4_r;
  logic [NUM_W-1:0]      num2_4_r;
  logic                  hit1_4_r;
  logic                  hit1_nxt;
  logic                  hit2;
  cell_link_t            head_r;
  cell_link_t            head_nxt;
  logic                  take1, take2, take3, take4, take5;

  cell_link_t            chain_link [QB+1];
  logic [QB:0]           chain_take;

  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_col_r;
  logic [OUT_W-1:0]      out_col_nxt;
  logic                  out_take;

  assign out_take = !out_valid_r || !out_stall;

  assign take5 = !head_r.valid || chain_take[0];
  assign take4 = !v4_r || take5;
  assign take3 = !v3_r || take4;
  assign take2 = !v2_r || take3;
  assign take1 = !v1_r || take2;

  assign in_stall = norm_st.busy || !take1;

  assign p2_nxt   = window_res_r * a1_r;
  assign num3_nxt = {{(NUM_W-D_W-1){norm_st.offset[D_W-1]}}, norm_st.offset, 1'b0}
                    + {{(NUM_W-PROD_W){1'b0}}, p2_r};
  assign hit1_nxt = !num3_r[NUM_W-1] && (num3_r[REM_W-1:0] < lim_r);

  // A miss in lat/lon mode is retried one turn further west.
  assign hit2 = latlon_mode_r && !num2_4_r[NUM_W-1] && (num2_4_r[REM_W-1:0] < lim_r);

  always_comb begin
    head_nxt.valid = v4_r;
    head_nxt.hit   = hit1_4_r || hit2;
    head_nxt.rem   = hit1_4_r ? num1_4_r[REM_W-1:0] : num2_4_r[REM_W-1:0];
    head_nxt.dv    = dv_start;
    head_nxt.q     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      head_r.valid <= 1'b0;
    end else begin
      if (take1) begin
        v1_r <= in_valid && !norm_st.busy;
        a1_r <= {in_window_column, 1'b1};
      end
      if (take2) begin
        v2_r <= v1_r;
        p2_r <= p2_nxt;
      end
      if (take3) begin
        v3_r   <= v2_r;
        num3_r <= num3_nxt;
      end
      if (take4) begin
        v4_r     <= v3_r;
        num1_4_r <= num3_r;
        num2_4_r <= num3_r - TWO_TURN;
        hit1_4_r <= hit1_nxt;
      end
      if (take5) begin
        head_r <= head_nxt;
      end
    end
  end

  assign chain_link[0]  = head_r;
  assign chain_take[QB] = out_take;

  for (genvar k = 0; k < QB; k++) begin : g_cell
    rcrm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .link_in  (chain_link[k]),
      .take_in  (chain_take[k+1]),
      .link_out (chain_link[k+1]),
      .take_out (chain_take[k])
    );
  end

  assign out_col_nxt = chain_link[QB].hit ? chain_link[QB].q + OUT_W'(1) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= chain_link[QB].valid;
      out_col_r   <= out_col_nxt;
    end
  end

  assign out_valid                  = out_valid_r;
  assign out_source_column_plus_one = out_col_r;

  a_accepted_beat_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v1_r)
    else $error("accepted beat missing from the first stage");

  a_row_end_holds: assert property (@(posedge clk) disable iff (!rst_n)
    chain_link[QB].valid && !chain_take[QB]
    |=> chain_link[QB].valid && $stable(chain_link[QB].q))
    else $error("divider row dropped or changed a waiting beat");

endmodule

`default_nettype wire

// ===== src/rcrm_turn_norm.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rcrm_turn_norm
  import rcrm_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [WEST_W-1:0] window_west,
  input  wire logic signed [WEST_W-1:0] source_west,
  input  wire logic                     latlon_mode,
  output norm_status_t                  status
);

  // A turn is 45 << (FRACTION_BITS + 3), and 4096 is 1 modulo 45, so the remainder
  // comes from a sum of 12-bit chunks and a short reciprocal step.
  localparam int SH = FRACTION_BITS + 3;
  localparam int TW = FRACTION_BITS + 9;
  localparam logic [TW-1:0]         TURN      = TW'(360) << FRACTION_BITS;
  localparam logic signed [D_W-1:0] TURN_D    = D_W'(TURN);
  localparam logic [25:0]           RECIP_45  = 26'd5826;
  localparam logic [12:0]           MOD_45    = 13'd45;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_FOLD = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]            state_r;
  logic signed [D_W-1:0] d_raw_r;
  logic [D_W-1:0]        mag_r;
  logic [13:0]           sum_r;
  logic [12:0]           fold_r;
  logic [7:0]            q45_r;
  logic signed [D_W-1:0] offset_r;

  logic signed [D_W-1:0] d_load;
  logic [D_W-1:0]        mag_load;
  logic [47:0]           chunks;
  logic [13:0]           sum_nxt;
  logic [12:0]           fold_nxt;
  logic [7:0]            q45_nxt;
  logic [5:0]            r45;
  logic [TW-1:0]         rem_nxt;
  logic signed [D_W-1:0] rem_d;
  logic signed [D_W-1:0] offset_nxt;

  assign d_load   = {window_west[WEST_W-1], window_west} - {source_west[WEST_W-1], source_west};
  assign mag_load = d_load[D_W-1] ? D_W'(-d_load) : D_W'(d_load);

  assign chunks   = 48'(mag_r >> SH);
  assign sum_nxt  = 14'(chunks[11:0]) + 14'(chunks[23:12]) + 14'(chunks[35:24])
                    + 14'(chunks[47:36]);
  assign fold_nxt = 13'(sum_r[13:12]) + 13'(sum_r[11:0]);
  // Exact quotient by 45 for every folded value below 10082.
  assign q45_nxt  = 8'((26'(fold_r) * RECIP_45) >> 18);
  assign r45      = 6'(fold_r - 13'(q45_r) * MOD_45);
  assign rem_nxt  = {r45, mag_r[SH-1:0]};
  assign rem_d    = {{(D_W-TW){1'b0}}, rem_nxt};

  // In lat/lon mode, bring the offset into [0, turn]; a positive multiple of a turn stays a full turn.
  always_comb begin
    offset_nxt = d_raw_r;
    if (latlon_mode) begin
      if (d_raw_r > TURN_D) begin
        offset_nxt = (rem_nxt == '0) ? TURN_D : rem_d;
      end else if (d_raw_r < 0) begin
        offset_nxt = (rem_nxt == '0) ? '0 : TURN_D - rem_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      offset_r <= '0;
    end else if (start) begin
      state_r <= ST_LOAD;
    end else begin
      case (state_r)
        ST_IDLE: begin
        end
        ST_LOAD: begin
          d_raw_r <= d_load;
          mag_r   <= mag_load;
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          sum_r   <= sum_nxt;
          state_r <= ST_FOLD;
        end
        ST_FOLD: begin
          fold_r  <= fold_nxt;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          q45_r   <= q45_nxt;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          offset_r <= offset_nxt;
          state_r  <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign status.busy   = (state_r != ST_IDLE);
  assign status.offset = offset_r;

  a_offset_in_turn: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) && $past(state_r == ST_DONE) && latlon_mode
    |-> (offset_r >= 0) && (offset_r <= TURN_D))
    else $error("reduced west offset outside one turn");

endmodule

`default_nettype wire

// ===== src/rcrm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rcrm_cell
  import rcrm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cell_link_t  link_in,
  input  wire logic        take_in,
  output cell_link_t       link_out,
  output logic             take_out
);

  cell_link_t link_r;
  cell_link_t link_nxt;
  logic       step;

  // One restoring division step: the divisor halves on its way down the row.
  assign step = link_in.hit && (link_in.rem >= link_in.dv);

  always_comb begin
    link_nxt       = link_in;
    link_nxt.rem   = step ? link_in.rem - link_in.dv : link_in.rem;
    link_nxt.dv    = link_in.dv >> 1;
    link_nxt.q     = {link_in.q[OUT_W-2:0], step};
  end

  assign take_out = !link_r.valid || take_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r.valid <= 1'b0;
    end else if (take_out) begin
      link_r <= link_nxt;
    end
  end

  assign link_out = link_r;

  a_miss_has_no_quotient: assert property (@(posedge clk) disable iff (!rst_n)
    link_in.valid && !link_in.hit |-> (link_in.q == '0))
    else $error("quotient bits set on a missed column");

endmodule

`default_nettype wire

// ===== verif/tb_raster_column_resample_map_top.sv =====
`timescale 1ns / 1ps

module tb_raster_column_resample_map_top
  import rcrm_pkg::*;
();

  localparam int     MAX_COLS      = 65536;
  localparam int     FRAC_BITS     = 16;
  localparam longint DEG           = longint'(1) << FRAC_BITS;
  localparam longint TURN          = 360 * DEG;
  localparam longint unsigned RES_MASK = (longint'(1) << RES_W) - 1;
  localparam int     IDLE_LIMIT    = 5000;
  localparam int     LONG_HOLD     = 400;
  localparam int     RANDOM_PHASES = 30;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [IDX_W-1:0]     in_window_column = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OUT_W-1:0]     out_source_column_plus_one;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  raster_column_resample_map_top u_dut (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .in_valid                   (in_valid),
    .in_stall                   (in_stall),
    .in_window_column           (in_window_column),
    .out_valid                  (out_valid),
    .out_stall                  (out_stall),
    .out_source_column_plus_one (out_source_column_plus_one),
    .cfg_valid                  (cfg_valid),
    .cfg_ready                  (cfg_ready),
    .cfg_index                  (cfg_index),
    .cfg_data                   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the mapping registers, updated as each write is taken.
  logic signed [WEST_W-1:0] m_window_west    = '0;
  logic [RES_W-1:0]         m_window_res     = 47'd65536;
  logic signed [WEST_W-1:0] m_source_west    = '0;
  logic [RES_W-1:0]         m_source_res     = 47'd65536;
  logic [COLS_W-1:0]        m_source_columns = 17'd1;
  logic                     m_latlon         = 1'b0;

  logic [IDX_W-1:0] pending_cols[$];
  logic [OUT_W-1:0] expected_src_cols[$];

  int               mismatches = 0;
  int               burst_left = 0;
  int               gap_left = 0;
  int               hold_req = 0;
  int               hold_seen = 0;
  int               hold_left = 0;
  int               stall_mode = 0;
  int               stall_window = 0;
  int               idle_cycles = 0;
  logic [OUT_W-1:0] want_col;
  longint unsigned  hit_hint;

  // Source column plus one for a given west offset, or zero on a miss.
  // Works as floor((2*offset + window_res*(2i+1)) / (2*source_res)), exact.
  function automatic logic [OUT_W-1:0] column_for_offset(longint offset,
                                                          logic [OUT_W-1:0] odd_col,
                                                          logic [COLS_W-1:0] cols);
    logic signed [129:0] num;
    logic [129:0]        step;
    logic [129:0]        lim;
    logic [63:0]         prod;
    if (m_source_res == '0 || cols == '0) return '0;
    prod = 64'(m_window_res) * 64'(odd_col);
    num  = offset;
    num  = num <<< 1;
    num  = num + $signed({66'd0, prod});
    if (num < 0) return '0;
    step = {82'd0, m_source_res, 1'b0};
    lim  = step * {113'd0, cols};
    if ($unsigned(num) >= lim) return '0;
    return OUT_W'($unsigned(num) / step + 1);
  endfunction

  function automatic logic [OUT_W-1:0] nearest_source_column(logic [IDX_W-1:0] col);
    longint            offset;
    longint            rem;
    logic [COLS_W-1:0] cols;
    logic [OUT_W-1:0]  odd_col;
    logic [OUT_W-1:0]  hit;
    offset  = m_window_west;
    offset  = offset - longint'(m_source_west);
    cols    = (m_source_columns > MAX_COLS) ? COLS_W'(MAX_COLS) : m_source_columns;
    odd_col = {col, 1'b1};
    if (m_latlon) begin
      // Bring the west offset into one turn of the source west edge.
      if (offset > TURN) begin
        rem    = offset % TURN;
        offset = (rem == 0) ? TURN : rem;
      end else if (offset < 0) begin
        rem = offset % TURN;
        if (rem < 0) rem = rem + TURN;
        offset = rem;
      end
    end
    hit = column_for_offset(offset, odd_col, cols);
    if (hit == '0 && m_latlon) hit = column_for_offset(offset - TURN, odd_col, cols);
    return hit;
  endfunction

  function automatic longint unsigned wide_rand();
    return {$urandom, $urandom};
  endfunction

  // Called at a rising edge; leaves cfg_valid high so back-to-back writes
  // never lower and raise it in the same step.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WINDOW_WEST:    m_window_west    = value;
      CFG_WINDOW_RES:     m_window_res     = value[RES_W-1:0];
      CFG_SOURCE_WEST:    m_source_west    = value;
      CFG_SOURCE_RES:     m_source_res     = value[RES_W-1:0];
      CFG_SOURCE_COLUMNS: m_source_columns = value[COLS_W-1:0];
      CFG_LATLON_MODE:    m_latlon         = value[0];
      default: ;
    endcase
  endtask

  task automatic write_setting(longint ww, longint unsigned wr, longint sw,
                               longint unsigned sr, longint unsigned cols, bit ll);
    write_reg(CFG_WINDOW_WEST, CFG_W'(ww));
    write_reg(CFG_WINDOW_RES, CFG_W'(wr));
    write_reg(CFG_SOURCE_WEST, CFG_W'(sw));
    write_reg(CFG_SOURCE_RES, CFG_W'(sr));
    write_reg(CFG_SOURCE_COLUMNS, CFG_W'(cols));
    write_reg(CFG_LATLON_MODE, CFG_W'(ll));
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_cols.size() != 0 || in_valid || expected_src_cols.size() != 0);
  endtask

  // Picks a mapping and writes it. Most settings keep the window over the
  // source so that hits dominate; a few are fully random.
  task automatic random_setting(output longint unsigned hint);
    longint unsigned sr, wr, cols, span;
    longint          sw, ww, offs;
    bit              ll;
    int              shape;
    int              turns;
    shape = $urandom_range(0, 7);
    ll    = $urandom_range(0, 1);
    if (shape == 0) begin
      sr   = wide_rand() & RES_MASK;
      wr   = wide_rand() & RES_MASK;
      sw   = longint'(wide_rand());
      ww   = longint'(wide_rand());
      cols = $urandom_range(0, 131071);
      span = sr * cols;
    end else begin
      case ($urandom_range(0, 7))
        0:       cols = MAX_COLS;
        1:       cols = $urandom_range(MAX_COLS + 1, 131071);
        2:       cols = $urandom_range(1, 4);
        default: cols = $urandom_range(1, 4096);
      endcase
      if (ll && shape < 4) begin
        // Source raster spanning the whole globe.
        sr = (longint'(TURN) + cols - 1) / cols;
        sw = longint'($urandom_range(0, TURN)) - TURN;
      end else begin
        sr = 1 + ((wide_rand() & RES_MASK) >> $urandom_range(16, 46));
        sw = longint'(int'($urandom)) * $urandom_range(1, 64);
      end
      case ($urandom_range(0, 2))
        0:       wr = sr;
        1:       wr = sr * $urandom_range(1, 8) / $urandom_range(1, 8);
        default: wr = 1 + ((wide_rand() & RES_MASK) >> $urandom_range(16, 46));
      endcase
      if (wr == 0) wr = 1;
      span = sr * cols;
      offs = longint'(span * $urandom_range(0, 1000) / 1000) - longint'(span / 4);
      ww   = sw + offs;
      if (ll) begin
        turns = $urandom_range(0, 6);
        ww    = ww + TURN * (turns - 3);
      end
    end
    hint = (wr == 0) ? 65535 : span / wr + 2;
    if (hint > 65535) hint = 65535;
    write_setting(ww, wr, sw, sr, cols, ll);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_src_cols.push_back(nearest_source_column(in_window_column));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_cols.size() > 0) begin
          in_valid         <= 1'b1;
          in_window_column <= pending_cols.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a stall pattern that changes every so often, plus long
  // hold-offs on request so the pipeline backs up into the input.
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (stall_window == 0) begin
        stall_mode   <= $urandom_range(0, 3);
        stall_window <= $urandom_range(16, 200);
      end else begin
        stall_window <= stall_window - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_src_cols.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: source_column_plus_one %0d",
                   out_source_column_plus_one);
      end else begin
        want_col = expected_src_cols.pop_front();
        if (out_source_column_plus_one !== want_col) begin
          mismatches++;
          if (mismatches <= 10)
            $display("source_column_plus_one mismatch: expected %0d, got %0d",
                     want_col, out_source_column_plus_one);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults straight out of reset.
    pending_cols.push_back(16'd0);
    pending_cols.push_back(16'd1);

    wait_drained();
    write_setting(0, DEG, 0, DEG, 100, 1'b0);
    pending_cols.push_back(16'd99);
    pending_cols.push_back(16'd100);
    pending_cols.push_back(16'hAAAA);
    pending_cols.push_back(16'h5555);

    // Centers land exactly on source cell edges and go to the eastern cell.
    wait_drained();
    write_setting(0, 2 * DEG, -DEG, DEG, 100, 1'b0);
    pending_cols.push_back(16'd0);
    pending_cols.push_back(16'd3);

    wait_drained();
    write_setting(0, DEG, -DEG, 0, 100, 1'b0);
    pending_cols.push_back(16'd5);

    wait_drained();
    write_setting(0, DEG, -DEG, DEG, 0, 1'b0);
    pending_cols.push_back(16'd0);

    // Column count above the maximum is clipped.
    wait_drained();
    write_setting(0, DEG, -DEG, DEG, 131071, 1'b0);
    pending_cols.push_back(16'd65535);
    pending_cols.push_back(16'd65534);

    // Zero window cell size maps every column to the west edge.
    wait_drained();
    write_setting(0, 0, -DEG, DEG, 100, 1'b0);
    pending_cols.push_back(16'd0);
    pending_cols.push_back(16'd65535);

    // Lat/lon: east end wraps back to the start of the globe.
    wait_drained();
    write_setting(170 * DEG, DEG, -180 * DEG, DEG, 360, 1'b1);
    pending_cols.push_back(16'd5);
    pending_cols.push_back(16'd9);
    pending_cols.push_back(16'd10);
    pending_cols.push_back(16'd200);

    // Offset of exactly two turns reduces to one full turn.
    wait_drained();
    write_setting(540 * DEG, DEG, -180 * DEG, DEG, 360, 1'b1);
    pending_cols.push_back(16'd0);

    wait_drained();
    write_setting(-905 * DEG, DEG, -180 * DEG, DEG, 360, 1'b1);
    pending_cols.push_back(16'd0);

    // Extremes of the west and cell size registers.
    wait_drained();
    write_setting(64'sh7FFF_FFFF_FFFF, 47'h7FFF_FFFF_FFFF, -64'sh8000_0000_0000,
                  47'h7FFF_FFFF_FFFF, MAX_COLS, 1'b0);
    pending_cols.push_back(16'd0);
    pending_cols.push_back(16'd65535);

    wait_drained();
    write_setting(64'sh7FFF_FFFF_FFFF, 47'h7FFF_FFFF_FFFF, -64'sh8000_0000_0000,
                  47'h7FFF_FFFF_FFFF, MAX_COLS, 1'b1);
    pending_cols.push_back(16'd0);

    wait_drained();
    write_setting(-64'sh8000_0000_0000, 1, 64'sh7FFF_FFFF_FFFF, 1, MAX_COLS, 1'b0);
    pending_cols.push_back(16'd0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      random_setting(hit_hint);
      if (phase % 10 == 3) hold_req <= hold_req + 1;
      repeat ($urandom_range(45, 75)) begin
        if ($urandom_range(0, 3) == 0)
          pending_cols.push_back(IDX_W'($urandom));
        else
          pending_cols.push_back(IDX_W'($urandom_range(0, hit_hint)));
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_src_cols.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rcrm_pkg.sv
src/rcrm_turn_norm.sv
src/rcrm_cell.sv
src/raster_column_resample_map_top.sv
verif/tb_raster_column_resample_map_top.sv
